// ===== hdl/qsu_pkg.sv =====
// qsu_pkg: shared types and constants of the quoted string unescaper.
// No dependencies; used by quoted_string_unescaper_top and qsu_checker.
package qsu_pkg;

	// scanner state
	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_STR  = 2'd1,
		MODE_ESC  = 2'd2
	} mode_t;

	// result kinds, carried in tuser[2:0]
	typedef logic [2:0] kind_t;
	localparam kind_t KIND_OPEN    = 3'd0;
	localparam kind_t KIND_CONTENT = 3'd1;
	localparam kind_t KIND_CLOSE   = 3'd2;
	localparam kind_t KIND_DROPPED = 3'd3;
	localparam kind_t KIND_UNTERM  = 3'd4;

	typedef logic [7:0] byte_t;

	// character codes
	localparam byte_t CH_BSL   = 8'h5C;
	localparam byte_t CH_DQ    = 8'h22;
	localparam byte_t CH_SQ    = 8'h27;
	localparam byte_t CH_SLASH = 8'h2F;
	localparam byte_t CH_SPACE = 8'h20;
	localparam byte_t CH_B     = 8'h62;
	localparam byte_t CH_F     = 8'h66;
	localparam byte_t CH_N     = 8'h6E;
	localparam byte_t CH_R     = 8'h72;
	localparam byte_t CH_T     = 8'h74;
	localparam byte_t CC_BS    = 8'h08;
	localparam byte_t CC_FF    = 8'h0C;
	localparam byte_t CC_LF    = 8'h0A;
	localparam byte_t CC_CR    = 8'h0D;
	localparam byte_t CC_TAB   = 8'h09;
	localparam byte_t CH_NUL   = 8'h00;

endpackage

// ===== hdl/quoted_string_unescaper_top.sv =====
// quoted_string_unescaper_top: byte-stream scanner and decoder for quoted strings.
// Depends on qsu_pkg.
//
// The block takes one byte per item on the slave stream and finds strings in
// single or double quotes. A quote outside a string opens one (result kind open,
// tdata = the quote); the same quote closes it (kind close) unless the raw byte
// before it was a backslash. Bytes inside are passed as content, with backslash
// escapes decoded: b f n r t to control codes, space or backslash to a backslash,
// slash to slash, either quote to itself (tuser[3] set when it differs from the
// delimiter). Any other escaped byte comes out as kind "dropped" carrying that
// byte. An item with tlast high marks end of input and its tdata is ignored;
// inside a string it yields kind "unterminated" with tdata zero and the scanner
// returns to idle. Bytes outside a string and end outside a string give no result.
// Rate: one item per cycle sustained while the master side takes results; an
// accepted item is held in the input register, then passes the decode logic
// into the result register, which drives the master side. The scanner state
// updates in the same pass, as the result register is loaded.
// No clearing pass after reset.
module quoted_string_unescaper_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic       s_tlast,   // is_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [3:0] m_tuser    // [2:0] kind, [3] quote_mismatch
);

	// input register
	logic                valid_s1;
	qsu_pkg::byte_t      data_s1;
	logic                last_s1;

	// scanner state
	qsu_pkg::mode_t      mode_q;
	logic                delim_dq_q;
	logic                prev_bsl_q;

	// result register
	logic                out_vld_q;
	qsu_pkg::byte_t      out_byte_q;
	qsu_pkg::kind_t      out_kind_q;
	logic                out_mism_q;

	// decode results
	qsu_pkg::mode_t      mode_d;
	logic                delim_dq_d;
	logic                prev_bsl_d;
	logic                res_vld;
	qsu_pkg::byte_t      res_byte;
	qsu_pkg::kind_t      res_kind;
	logic                res_mism;
	qsu_pkg::byte_t      delim;

	logic                advance;

	// stage 1 moves on whenever the result register is free or being drained
	assign advance  = !out_vld_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {out_mism_q, out_kind_q};

	assign delim = delim_dq_q ? qsu_pkg::CH_DQ : qsu_pkg::CH_SQ;

	always_comb begin
		mode_d     = mode_q;
		delim_dq_d = delim_dq_q;
		prev_bsl_d = prev_bsl_q;
		res_vld    = 1'b0;
		res_byte   = data_s1;
		res_kind   = qsu_pkg::KIND_CONTENT;
		res_mism   = 1'b0;
		case (mode_q)
			qsu_pkg::MODE_STR, qsu_pkg::MODE_ESC: begin
				if (last_s1) begin
					// end of input inside a string
					mode_d     = qsu_pkg::MODE_IDLE;
					delim_dq_d = 1'b0;
					prev_bsl_d = 1'b0;
					res_vld    = 1'b1;
					res_byte   = qsu_pkg::CH_NUL;
					res_kind   = qsu_pkg::KIND_UNTERM;
				end else if (mode_q == qsu_pkg::MODE_STR) begin
					if (data_s1 == delim && !prev_bsl_q) begin
						mode_d     = qsu_pkg::MODE_IDLE;
						delim_dq_d = 1'b0;
						prev_bsl_d = 1'b0;
						res_vld    = 1'b1;
						res_kind   = qsu_pkg::KIND_CLOSE;
					end else if (data_s1 == qsu_pkg::CH_BSL) begin
						mode_d     = qsu_pkg::MODE_ESC;
						prev_bsl_d = 1'b1;
					end else begin
						prev_bsl_d = 1'b0;
						res_vld    = 1'b1;
					end
				end else begin
					// byte after an escaping backslash
					mode_d     = qsu_pkg::MODE_STR;
					prev_bsl_d = (data_s1 == qsu_pkg::CH_BSL);
					res_vld    = 1'b1;
					case (data_s1)
						qsu_pkg::CH_B:     res_byte = qsu_pkg::CC_BS;
						qsu_pkg::CH_F:     res_byte = qsu_pkg::CC_FF;
						qsu_pkg::CH_N:     res_byte = qsu_pkg::CC_LF;
						qsu_pkg::CH_R:     res_byte = qsu_pkg::CC_CR;
						qsu_pkg::CH_T:     res_byte = qsu_pkg::CC_TAB;
						qsu_pkg::CH_SPACE,
						qsu_pkg::CH_BSL:   res_byte = qsu_pkg::CH_BSL;
						qsu_pkg::CH_SLASH: res_byte = qsu_pkg::CH_SLASH;
						qsu_pkg::CH_DQ,
						qsu_pkg::CH_SQ:    res_mism = (data_s1 != delim);
						default:           res_kind = qsu_pkg::KIND_DROPPED;
					endcase
				end
			end
			default: begin
				// idle: only a quote does anything
				if (!last_s1 && (data_s1 == qsu_pkg::CH_SQ || data_s1 == qsu_pkg::CH_DQ)) begin
					mode_d     = qsu_pkg::MODE_STR;
					delim_dq_d = (data_s1 == qsu_pkg::CH_DQ);
					prev_bsl_d = 1'b0;
					res_vld    = 1'b1;
					res_kind   = qsu_pkg::KIND_OPEN;
				end
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// scanner state, updated as each item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= qsu_pkg::MODE_IDLE;
			delim_dq_q <= 1'b0;
			prev_bsl_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			mode_q     <= mode_d;
			delim_dq_q <= delim_dq_d;
			prev_bsl_q <= prev_bsl_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= valid_s1 && res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_vld) begin
			out_byte_q <= res_byte;
			out_kind_q <= res_kind;
			out_mism_q <= res_mism;
		end
	end

endmodule

// ===== hdl/qsu_checker.sv =====
// qsu_checker: port-level assertions for quoted_string_unescaper_top, plus bind.
// Depends on qsu_pkg and quoted_string_unescaper_top.
module qsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [3:0] m_tuser
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// only defined kinds leave the block
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[2:0] <= qsu_pkg::KIND_UNTERM)
		else $error("undefined result kind");

	// mismatch flag only on an escaped quote delivered as content
	a_mism: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3] |-> m_tuser[2:0] == qsu_pkg::KIND_CONTENT &&
			(m_tdata == qsu_pkg::CH_DQ || m_tdata == qsu_pkg::CH_SQ))
		else $error("mismatch flag on a non-quote result");

	// open and close carry a quote byte
	a_delim: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] == qsu_pkg::KIND_OPEN ||
			m_tuser[2:0] == qsu_pkg::KIND_CLOSE) |->
			(m_tdata == qsu_pkg::CH_DQ || m_tdata == qsu_pkg::CH_SQ) && !m_tuser[3])
		else $error("open or close without a quote byte");

	// unterminated carries a zero byte
	a_unterm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:0] == qsu_pkg::KIND_UNTERM |->
			m_tdata == qsu_pkg::CH_NUL && !m_tuser[3])
		else $error("unterminated result with nonzero fields");

endmodule

bind quoted_string_unescaper_top qsu_checker u_qsu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
